### hdl/prescaled_timer8_compare_match_core_macros.svh
// assertion macros used by the checker file
`ifndef PRESCALED_TIMER8_COMPARE_MATCH_CORE_MACROS_SVH
`define PRESCALED_TIMER8_COMPARE_MATCH_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define PTCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer checker: same-cycle property failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define PTCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer checker: next-cycle property failed");

`endif

### hdl/ptcm_pkg.sv
// types, codes and helper functions of the prescaled 8-bit timer
`timescale 1ns / 1ps
package ptcm_pkg;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_FORCE_A     = 3'd1,
    ACT_FORCE_B     = 3'd2,
    ACT_WRITE_COUNT = 3'd3,
    ACT_CLEAR_FLAGS = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CFG_CLOCK_SELECT = 3'd0,
    CFG_WAVEFORM     = 3'd1,
    CFG_COMPARE_A    = 3'd2,
    CFG_COMPARE_B    = 3'd3,
    CFG_PIN_ACTION_A = 3'd4,
    CFG_PIN_ACTION_B = 3'd5,
    CFG_IRQ_ENABLE   = 3'd6,
    CFG_PIN_DRIVE    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PIN_NONE   = 2'd0,
    PIN_TOGGLE = 2'd1,
    PIN_CLEAR  = 2'd2,
    PIN_SET    = 2'd3
  } pin_act_e;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_CTC    = 3'd2;

  // bit positions in flags, interrupt enable and irq vectors
  localparam int unsigned FLAG_OVF  = 0;
  localparam int unsigned FLAG_CMPA = 1;
  localparam int unsigned FLAG_CMPB = 2;

  localparam int unsigned CD_W = 11;

  typedef struct packed {
    logic [2:0] clock_select;
    logic [2:0] waveform_mode;
    logic [7:0] compare_a;
    logic [7:0] compare_b;
    logic [1:0] pin_action_a;
    logic [1:0] pin_action_b;
    logic [2:0] interrupt_enable;
    logic [1:0] pin_drive_enable;
  } cfg_t;

  // countdown reload request raised by a clock select write
  typedef struct packed {
    logic            load;
    logic [CD_W-1:0] div;
  } cd_load_t;

  typedef struct packed {
    logic [7:0] count;
    logic [2:0] flags;
    logic [2:0] irq;
    logic       pin_a;
    logic       pin_b;
  } result_t;

  function automatic logic [CD_W-1:0] divisor_of(input logic [2:0] sel);
    logic [CD_W-1:0] d;
    case (sel)
      3'd1:    d = 11'd1;
      3'd2:    d = 11'd8;
      3'd3:    d = 11'd64;
      3'd4:    d = 11'd256;
      3'd5:    d = 11'd1024;
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic logic apply_pin(input logic level, input logic [1:0] act,
                                     input logic driven);
    logic r;
    r = level;
    if (driven) begin
      case (pin_act_e'(act))
        PIN_TOGGLE: r = ~level;
        PIN_CLEAR:  r = 1'b0;
        PIN_SET:    r = 1'b1;
        default:    r = level;
      endcase
    end
    return r;
  endfunction

endpackage

### hdl/ptcm_cfg_regs.sv
// configuration register file of the timer
`timescale 1ns / 1ps
module ptcm_cfg_regs import ptcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o,
  output cd_load_t   cd_load_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CLOCK_SELECT: cfg_d.clock_select     = cfg_data_i[2:0];
        CFG_WAVEFORM:     cfg_d.waveform_mode    = cfg_data_i[2:0];
        CFG_COMPARE_A:    cfg_d.compare_a        = cfg_data_i;
        CFG_COMPARE_B:    cfg_d.compare_b        = cfg_data_i;
        CFG_PIN_ACTION_A: cfg_d.pin_action_a     = cfg_data_i[1:0];
        CFG_PIN_ACTION_B: cfg_d.pin_action_b     = cfg_data_i[1:0];
        CFG_IRQ_ENABLE:   cfg_d.interrupt_enable = cfg_data_i[2:0];
        CFG_PIN_DRIVE:    cfg_d.pin_drive_enable = cfg_data_i[1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // clock select write also reloads the prescaler countdown
  assign cd_load_o.load = cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_CLOCK_SELECT);
  assign cd_load_o.div  = divisor_of(cfg_data_i[2:0]);
  assign cfg_o          = cfg_q;

endmodule

### hdl/ptcm_engine.sv
// timer state and per-transaction next-state logic
`timescale 1ns / 1ps
module ptcm_engine import ptcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cd_load_t   cd_load_i,
  input  logic       step_en_i,
  input  logic [2:0] action_i,
  input  logic [7:0] value_i,
  output result_t    res_o
);

  logic [7:0]      cnt_q, cnt_d;
  logic [CD_W-1:0] cd_q, cd_d;
  logic [2:0]      flags_q, flags_d;
  logic            pin_a_q, pin_a_d;
  logic            pin_b_q, pin_b_d;
  logic [2:0]      irq;
  logic [CD_W-1:0] div;
  logic [7:0]      inc;
  logic            plain_mode;

  assign div        = divisor_of(cfg_i.clock_select);
  assign inc        = cnt_q + 8'd1;
  assign plain_mode = (cfg_i.waveform_mode == MODE_NORMAL) ||
                      (cfg_i.waveform_mode == MODE_CTC);

  always_comb begin
    cnt_d   = cnt_q;
    cd_d    = cd_q;
    flags_d = flags_q;
    pin_a_d = pin_a_q;
    pin_b_d = pin_b_q;
    irq     = '0;
    case (action_e'(action_i))
      ACT_TICK: begin
        if (div != '0) begin
          if (cd_q[CD_W-1:1] == '0) begin
            cd_d = div;
            if (plain_mode) begin
              cnt_d = inc;
              if (inc == 8'd0) begin
                flags_d[FLAG_OVF] = 1'b1;
                irq[FLAG_OVF]     = cfg_i.interrupt_enable[FLAG_OVF];
              end
              if (inc == cfg_i.compare_b) begin
                flags_d[FLAG_CMPB] = 1'b1;
                irq[FLAG_CMPB]     = cfg_i.interrupt_enable[FLAG_CMPB];
                pin_b_d = apply_pin(pin_b_q, cfg_i.pin_action_b, cfg_i.pin_drive_enable[1]);
              end
              if (inc == cfg_i.compare_a) begin
                flags_d[FLAG_CMPA] = 1'b1;
                irq[FLAG_CMPA]     = cfg_i.interrupt_enable[FLAG_CMPA];
                pin_a_d = apply_pin(pin_a_q, cfg_i.pin_action_a, cfg_i.pin_drive_enable[0]);
                if (cfg_i.waveform_mode == MODE_CTC) begin
                  cnt_d = 8'd0;
                end
              end
            end
          end else begin
            cd_d = cd_q - 11'd1;
          end
        end
      end
      ACT_FORCE_A: begin
        if (plain_mode) begin
          pin_a_d = apply_pin(pin_a_q, cfg_i.pin_action_a, cfg_i.pin_drive_enable[0]);
        end
      end
      ACT_FORCE_B: begin
        if (plain_mode) begin
          pin_b_d = apply_pin(pin_b_q, cfg_i.pin_action_b, cfg_i.pin_drive_enable[1]);
        end
      end
      ACT_WRITE_COUNT: cnt_d = value_i;
      ACT_CLEAR_FLAGS: flags_d = flags_q & ~value_i[2:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      cd_q    <= '0;
      flags_q <= '0;
      pin_a_q <= 1'b0;
      pin_b_q <= 1'b0;
    end else if (cd_load_i.load) begin
      cd_q <= cd_load_i.div;
    end else if (step_en_i) begin
      cnt_q   <= cnt_d;
      cd_q    <= cd_d;
      flags_q <= flags_d;
      pin_a_q <= pin_a_d;
      pin_b_q <= pin_b_d;
    end
  end

  assign res_o.count = cnt_d;
  assign res_o.flags = flags_d;
  assign res_o.irq   = irq;
  assign res_o.pin_a = pin_a_d;
  assign res_o.pin_b = pin_b_d;

endmodule

### hdl/ptcm_out_buf.sv
// result register with a skid stage behind it
`timescale 1ns / 1ps
module ptcm_out_buf import ptcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_ready_i,
  output result_t data_o
);

  result_t head_q, skid_q;
  logic    head_vq, skid_vq;
  logic    pop;

  assign pop     = head_vq && pop_ready_i;
  assign ready_o = !skid_vq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vq <= 1'b0;
      skid_vq <= 1'b0;
    end else begin
      if (skid_vq) begin
        if (pop) begin
          skid_vq <= 1'b0;
        end
      end else if (push_i && head_vq && !pop) begin
        skid_vq <= 1'b1;
      end
      if (!head_vq) begin
        head_vq <= push_i;
      end else if (pop && !skid_vq && !push_i) begin
        head_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vq) begin
      if (pop) begin
        head_q <= skid_q;
      end
    end else if (push_i) begin
      if (!head_vq || pop) begin
        head_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  assign valid_o = head_vq;
  assign data_o  = head_q;

endmodule

### hdl/prescaled_timer8_compare_match_core.sv
// top level of the prescaled 8-bit timer with two compare channels
`timescale 1ns / 1ps
// 8-bit timer/counter with prescaler (/1, /8, /64, /256, /1024 or stopped), two
// compare channels with output pins, overflow and compare flags and interrupt
// pulses. every input transaction is one cpu cycle tick or one cpu command, and
// each one gives exactly one result transaction with the counter, flags, irq
// pulses and pin levels after it. one transaction is accepted per clock: the
// whole update is done in the cycle of acceptance and lands in a result
// register, and the rate is one per cycle as long as the output side takes
// results; a skid stage lets one more transaction in while a result is
// stalled. configuration is written through a plain write port and is meant
// to change only while the timer is idle; writing the clock select reloads
// the prescaler countdown.
module prescaled_timer8_compare_match_core import ptcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input transaction
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [7:0] value_i,
  // result transaction
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] count_o,
  output logic [2:0] flags_o,
  output logic       overflow_irq_o,
  output logic       compare_a_irq_o,
  output logic       compare_b_irq_o,
  output logic       pin_a_o,
  output logic       pin_b_o
);

  cfg_t     cfg;
  cd_load_t cd_load;
  result_t  step_res;
  result_t  out_res;
  logic     accept;

  // transaction taken whenever the skid stage is free
  assign accept = in_valid_i && in_ready_o;

  ptcm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cd_load_o   (cd_load)
  );

  // counter, prescaler, flags and pins, updated once per accepted transaction
  ptcm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cd_load_i (cd_load),
    .step_en_i (accept),
    .action_i  (action_i),
    .value_i   (value_i),
    .res_o     (step_res)
  );

  // result register plus skid entry decouples the two handshakes
  ptcm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (step_res),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (out_res)
  );

  assign count_o         = out_res.count;
  assign flags_o         = out_res.flags;
  assign overflow_irq_o  = out_res.irq[FLAG_OVF];
  assign compare_a_irq_o = out_res.irq[FLAG_CMPA];
  assign compare_b_irq_o = out_res.irq[FLAG_CMPB];
  assign pin_a_o         = out_res.pin_a;
  assign pin_b_o         = out_res.pin_b;

endmodule

### hdl/ptcm_checker.sv
// port-level checker of the timer and its bind to the top level
`timescale 1ns / 1ps
`include "prescaled_timer8_compare_match_core_macros.svh"
module ptcm_checker import ptcm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] count_o,
  input logic [2:0] flags_o,
  input logic       overflow_irq_o,
  input logic       compare_a_irq_o,
  input logic       compare_b_irq_o
);

  // a stalled result keeps its value
  `PTCM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(count_o) && $stable(flags_o))
  // back-pressure only while a result is pending
  `PTCM_ASSERT_NOW(a_ready_low_pending, !in_ready_o, out_valid_o)
  // an interrupt pulse always comes with its flag set in the same result
  `PTCM_ASSERT_NOW(a_ovf_flag, out_valid_o && overflow_irq_o, flags_o[FLAG_OVF])
  `PTCM_ASSERT_NOW(a_cmpa_flag, out_valid_o && compare_a_irq_o, flags_o[FLAG_CMPA])
  `PTCM_ASSERT_NOW(a_cmpb_flag, out_valid_o && compare_b_irq_o, flags_o[FLAG_CMPB])

endmodule

bind prescaled_timer8_compare_match_core ptcm_checker u_ptcm_checker (.*);
